/* hdl/mbet_pkg.sv */
`default_nettype none
package mbet_pkg;

	localparam int FRAC_BITS = 28;
	localparam int MAX_ITERATIONS = 1024;
	localparam int COORD_W = 12;
	localparam int CNT_W = 11;
	localparam int RED_W = 9;
	localparam int COLOR_W = 8;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int IN_W = 24;
	localparam int OUT_W = 40;
	localparam int ROM_DEPTH = MAX_ITERATIONS + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REAL_ORIGIN = 3'd0,
		REG_IMAG_ORIGIN = 3'd1,
		REG_REAL_STEP   = 3'd2,
		REG_IMAG_STEP   = 3'd3,
		REG_ITER_LIMIT  = 3'd4
	} cfg_reg_t;

	localparam logic signed [CFG_W-1:0] RESET_REAL_ORIGIN = -32'sd536870912;
	localparam logic signed [CFG_W-1:0] RESET_IMAG_ORIGIN = -32'sd268435456;
	localparam logic signed [CFG_W-1:0] RESET_REAL_STEP = 32'sd196608;
	localparam logic signed [CFG_W-1:0] RESET_IMAG_STEP = 32'sd131072;
	localparam logic [CNT_W-1:0] RESET_ITER_LIMIT = 11'd255;

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam logic [63:0] ESCAPE_LEVEL = 64'd1 << (2 * FRAC_BITS + 2);

	localparam logic [63:0] INV_TWO_PI_HI = 64'h28BE60DB9391054A;
	localparam logic [63:0] INV_TWO_PI_LO = 64'h7F09D5F47D4D3770;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
	localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
	localparam logic [63:0] LOW32 = 64'h00000000FFFFFFFF;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// trunc(n*sin n) rem 256 in q62 integer arithmetic, sign of the dividend
	function automatic logic [RED_W-1:0] red_of(input logic [CNT_W-1:0] n_in);
		logic [63:0] n;
		logic [63:0] lo_part;
		logic [63:0] t;
		logic [63:0] r4;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] s;
		logic [63:0] ip;
		logic [127:0] p;
		logic [1:0] q;
		int unsigned k;
		n = 64'(n_in);
		lo_part = (((INV_TWO_PI_LO >> 32) * n) + (((INV_TWO_PI_LO & LOW32) * n) >> 32)) >> 32;
		t = INV_TWO_PI_HI * n + lo_part;
		q = t[63:62];
		r4 = t << 2;
		p = 128'(r4) * 128'(HALF_PI_Q62);
		x = p[127:64];
		p = 128'(x) * 128'(x);
		x2 = p[125:62];
		if (q[0]) begin
			term = ONE_Q62;
			sum = term;
			for (k = 2; k <= 28; k += 2) begin
				p = 128'(term) * 128'(x2);
				term = p[125:62] / 64'(k * (k - 1));
				if (((k / 2) & 1) != 0) sum = sum - term;
				else sum = sum + term;
			end
		end else begin
			term = x;
			sum = x;
			for (k = 3; k <= 29; k += 2) begin
				p = 128'(term) * 128'(x2);
				term = p[125:62] / 64'(k * (k - 1));
				if ((((k - 1) / 2) & 1) != 0) sum = sum - term;
				else sum = sum + term;
			end
		end
		s = sum;
		if (s > ONE_Q62) s = s[63] ? 64'd0 : ONE_Q62;
		ip = ((n * (s >> 32)) + ((n * (s & LOW32)) >> 32)) >> 30;
		ip = ip & 64'hFF;
		if (q[1]) ip = 64'd0 - ip;
		return ip[RED_W-1:0];
	endfunction

	function automatic logic [ROM_DEPTH*RED_W-1:0] build_red_rom();
		logic [ROM_DEPTH*RED_W-1:0] rom;
		int unsigned i;
		rom = '0;
		for (i = 0; i < ROM_DEPTH; i++) begin
			rom[i*RED_W +: RED_W] = red_of(CNT_W'(i));
		end
		return rom;
	endfunction

	localparam logic [ROM_DEPTH*RED_W-1:0] RED_ROM = build_red_rom();

endpackage
`default_nettype wire

/* hdl/mandelbrot_escape_time_pixel.sv */
`default_nettype none
// Escape-time pixel engine. A beat on s_* carries one pixel coordinate; the
// block maps it to c = origin + coordinate*step (Q4.28, saturated), iterates
// z = z*z + c from zero until |z|^2 reaches 4.0 or the count reaches the
// limit (capped at 1024), and returns one beat on m_* with the count and an
// rgb colour. Every product comes from one shared 33x33 signed multiplier:
// MAP_R, MAP_I and MAP_IA map the point, each iteration steps through SQ_R
// (zr^2), SQ_I (zi^2), CROSS (zr*zi) and UPDATE (update and escape test),
// and EMIT looks up the colour. s_tready is high only between pixels; a
// finished result waits in its output register while the next pixel is
// taken and worked on.
module mandelbrot_escape_time_pixel (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [mbet_pkg::IN_W-1:0]           s_tdata,   // column, row
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [mbet_pkg::OUT_W-1:0]               m_tdata,   // escape_count, red, green, blue
	input  wire logic                                cfg_we,
	input  wire logic [mbet_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [mbet_pkg::CFG_W-1:0]          cfg_data
);
	import mbet_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MAP_R  = 9'b000000010,
		ST_MAP_I  = 9'b000000100,
		ST_MAP_IA = 9'b000001000,
		ST_SQ_R   = 9'b000010000,
		ST_SQ_I   = 9'b000100000,
		ST_CROSS  = 9'b001000000,
		ST_UPDATE = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic signed [CFG_W-1:0] real_origin_q;
	logic signed [CFG_W-1:0] imag_origin_q;
	logic signed [CFG_W-1:0] real_step_q;
	logic signed [CFG_W-1:0] imag_step_q;
	logic [CNT_W-1:0]        iter_limit_q;

	logic [COORD_W-1:0] column_q;
	logic [COORD_W-1:0] row_q;
	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   n_q;
	logic signed [31:0] cr_q;
	logic signed [31:0] ci_q;
	logic signed [31:0] zr_q;
	logic signed [31:0] zi_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] rr_q;
	logic signed [63:0] ii_q;

	logic                 out_valid_q;
	logic [CNT_W-1:0]     count_q;
	logic [RED_W-1:0]     red_q;
	logic [COLOR_W-1:0]   green_q;
	logic [COLOR_W-1:0]   blue_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic               accept;
	logic               at_limit;
	logic               escaped;
	logic               emit_load;
	logic [63:0]        sq_sum;
	logic signed [63:0] diff;
	logic signed [31:0] zr_next;
	logic signed [31:0] zi_next;
	logic signed [31:0] cr_next;
	logic signed [31:0] ci_next;
	logic [CNT_W-1:0]   limit_in;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign at_limit  = (n_q == limit_q);
	assign sq_sum    = $unsigned(rr_q) + $unsigned(ii_q);
	assign escaped   = (sq_sum >= ESCAPE_LEVEL);
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign diff      = rr_q - ii_q;
	assign zr_next   = sat32((diff >>> FRAC_BITS) + 64'(cr_q));
	assign zi_next   = sat32((prod_q >>> (FRAC_BITS - 1)) + 64'(ci_q));
	assign cr_next   = sat32(64'(real_origin_q) + prod_q);
	assign ci_next   = sat32(64'(imag_origin_q) + prod_q);
	assign limit_in  = (iter_limit_q > CNT_W'(MAX_ITERATIONS)) ?
		CNT_W'(MAX_ITERATIONS) : iter_limit_q;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_MAP_R: begin
				mul_a = $signed({{(33 - COORD_W){1'b0}}, column_q});
				mul_b = 33'(real_step_q);
			end
			ST_MAP_I: begin
				mul_a = $signed({{(33 - COORD_W){1'b0}}, row_q});
				mul_b = 33'(imag_step_q);
			end
			ST_SQ_R: begin
				mul_a = 33'(zr_q);
				mul_b = 33'(zr_q);
			end
			ST_SQ_I: begin
				mul_a = 33'(zi_q);
				mul_b = 33'(zi_q);
			end
			default: begin
				mul_a = 33'(zr_q);
				mul_b = 33'(zi_q);
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_origin_q <= RESET_REAL_ORIGIN;
			imag_origin_q <= RESET_IMAG_ORIGIN;
			real_step_q   <= RESET_REAL_STEP;
			imag_step_q   <= RESET_IMAG_STEP;
			iter_limit_q  <= RESET_ITER_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REAL_ORIGIN: real_origin_q <= cfg_data;
				REG_IMAG_ORIGIN: imag_origin_q <= cfg_data;
				REG_REAL_STEP:   real_step_q   <= cfg_data;
				REG_IMAG_STEP:   imag_step_q   <= cfg_data;
				REG_ITER_LIMIT:  iter_limit_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready && !emit_load) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= '0;
						limit_q <= limit_in;
						state_q <= ST_MAP_R;
					end
				end
				ST_MAP_R:  state_q <= ST_MAP_I;
				ST_MAP_I:  state_q <= ST_MAP_IA;
				ST_MAP_IA: state_q <= ST_SQ_R;
				ST_SQ_R:   state_q <= at_limit ? ST_EMIT : ST_SQ_I;
				ST_SQ_I:   state_q <= ST_CROSS;
				ST_CROSS:  state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (escaped) begin
						state_q <= ST_EMIT;
					end else begin
						n_q     <= n_q + CNT_W'(1);
						state_q <= ST_SQ_R;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath and colour rom
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					column_q <= s_tdata[COORD_W-1:0];
					row_q    <= s_tdata[2*COORD_W-1:COORD_W];
					zr_q     <= '0;
					zi_q     <= '0;
				end
			end
			ST_MAP_R: prod_q <= mul_p[63:0];
			ST_MAP_I: begin
				prod_q <= mul_p[63:0];
				cr_q   <= cr_next;
			end
			ST_MAP_IA: ci_q <= ci_next;
			ST_SQ_R:   prod_q <= mul_p[63:0];
			ST_SQ_I: begin
				rr_q   <= prod_q;
				prod_q <= mul_p[63:0];
			end
			ST_CROSS: begin
				ii_q   <= prod_q;
				prod_q <= mul_p[63:0];
			end
			ST_UPDATE: begin
				if (!escaped) begin
					zr_q <= zr_next;
					zi_q <= zi_next;
				end
			end
			ST_EMIT: begin
				if (emit_load) begin
					count_q <= n_q;
					red_q   <= RED_ROM[n_q*RED_W +: RED_W];
					green_q <= {n_q[COLOR_W-2:0], 1'b0};
					blue_q  <= n_q[COLOR_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - CNT_W - RED_W - 2*COLOR_W){1'b0}},
		blue_q, green_q, red_q, count_q};

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= limit_q)
		else $error("iteration count passed the limit");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && out_valid_q && !m_tready |=> state_q == ST_EMIT)
		else $error("result dropped while output register full");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MAP_R)
		else $error("accepted beat did not start mapping");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CNT_W-1:0] <= CNT_W'(MAX_ITERATIONS))
		else $error("escape count out of range");

endmodule
`default_nettype wire

/* dv/mandelbrot_escape_time_pixel_tb.sv */
class escape_shades;
	localparam logic [63:0] RECIP_HI = 64'h28BE60DB9391054A;
	localparam logic [63:0] RECIP_LO = 64'h7F09D5F47D4D3770;
	localparam logic [63:0] HALF_PI = 64'h6487ED5110B4611A;
	localparam logic [63:0] UNIT = 64'h4000000000000000;
	localparam logic [63:0] LOW_WORD = 64'h00000000FFFFFFFF;
	localparam logic [63:0] ESCAPE_SQ = 64'h0400000000000000;
	localparam int FRAC = 28;
	localparam int COUNT_CAP = 1024;

	typedef struct packed {
		logic [10:0] count;
		logic [8:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	logic signed [31:0] real_origin;
	logic signed [31:0] imag_origin;
	logic signed [31:0] real_step;
	logic signed [31:0] imag_step;
	logic [10:0] iter_limit;
	logic [8:0] red_table [0:COUNT_CAP];
	shade_t awaited[$];
	int errors;
	int pixels;
	int escaped;
	int max_seen;
	int neg_reds;

	function new();
		real_origin = -32'sd536870912;
		imag_origin = -32'sd268435456;
		real_step = 32'sd196608;
		imag_step = 32'sd131072;
		iter_limit = 11'd255;
		errors = 0;
		pixels = 0;
		escaped = 0;
		max_seen = 0;
		neg_reds = 0;
		for (int n = 0; n <= COUNT_CAP; n++) begin
			red_table[n] = red_shade(n);
		end
	endfunction

	// trunc(n*sin n) rem 256 in q62 integer arithmetic
	function logic [8:0] red_shade(int n);
		logic [63:0] cnt;
		logic [63:0] frac_lo;
		logic [63:0] turns;
		logic [63:0] rest;
		logic [63:0] ang;
		logic [63:0] ang_sq;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] s;
		logic [63:0] whole;
		logic [127:0] prod;
		logic [1:0] quad;
		bit minus;
		int k;
		cnt = 64'(n);
		frac_lo = (((RECIP_LO >> 32) * cnt) + (((RECIP_LO & LOW_WORD) * cnt) >> 32)) >> 32;
		turns = RECIP_HI * cnt + frac_lo;
		quad = turns[63:62];
		rest = turns << 2;
		prod = {64'd0, rest} * {64'd0, HALF_PI};
		ang = prod[127:64];
		prod = {64'd0, ang} * {64'd0, ang};
		ang_sq = prod[125:62];
		// odd quadrants take the cosine series, even ones the sine series
		term = quad[0] ? UNIT : ang;
		acc = term;
		minus = 1'b1;
		for (k = quad[0] ? 2 : 3; k <= 29; k += 2) begin
			prod = {64'd0, term} * {64'd0, ang_sq};
			term = prod[125:62] / 64'(k * (k - 1));
			acc = minus ? acc - term : acc + term;
			minus = !minus;
		end
		s = acc;
		if (s > UNIT) begin
			s = s[63] ? 64'd0 : UNIT;
		end
		whole = ((cnt * (s >> 32)) + ((cnt * (s & LOW_WORD)) >> 32)) >> 30;
		whole = whole & 64'hFF;
		if (quad[1]) begin
			whole = 64'd0 - whole;
		end
		return whole[8:0];
	endfunction

	function void write_register(logic [2:0] idx, logic [31:0] d);
		case (idx)
			mbet_pkg::REG_REAL_ORIGIN: real_origin = d;
			mbet_pkg::REG_IMAG_ORIGIN: imag_origin = d;
			mbet_pkg::REG_REAL_STEP: real_step = d;
			mbet_pkg::REG_IMAG_STEP: imag_step = d;
			mbet_pkg::REG_ITER_LIMIT: iter_limit = d[10:0];
			default: ;
		endcase
	endfunction

	function logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function logic signed [31:0] map_axis(logic [11:0] coord, logic signed [31:0] origin,
			logic signed [31:0] step);
		return clamp32(longint'(origin) + longint'(coord) * longint'(step));
	endfunction

	function int escape_depth(logic [11:0] column, logic [11:0] row);
		longint zr;
		longint zi;
		longint cr;
		longint ci;
		longint nr;
		longint ni;
		logic [63:0] mag;
		int cap;
		int n;
		cr = map_axis(column, real_origin, real_step);
		ci = map_axis(row, imag_origin, imag_step);
		cap = (iter_limit > 11'(COUNT_CAP)) ? COUNT_CAP : int'(iter_limit);
		zr = 0;
		zi = 0;
		n = 0;
		while (n < cap) begin
			mag = zr * zr + zi * zi;
			if (mag >= ESCAPE_SQ) begin
				escaped++;
				break;
			end
			nr = clamp32(((zr * zr - zi * zi) >>> FRAC) + cr);
			ni = clamp32(((zr * zi) >>> (FRAC - 1)) + ci);
			zr = nr;
			zi = ni;
			n++;
		end
		return n;
	endfunction

	function void note_pixel(logic [11:0] column, logic [11:0] row);
		shade_t s;
		int n;
		n = escape_depth(column, row);
		s.count = n[10:0];
		s.red = red_table[n];
		s.green = 8'(2 * n);
		s.blue = n[7:0];
		awaited.push_back(s);
		pixels++;
		if (n > max_seen) begin
			max_seen = n;
		end
		if (s.red[8]) begin
			neg_reds++;
		end
	endfunction

	function void check_beat(logic [39:0] d);
		shade_t want;
		if (awaited.size() == 0) begin
			$error("result beat with no pixel outstanding: %h", d);
			errors++;
			return;
		end
		want = awaited.pop_front();
		if (d[10:0] !== want.count) begin
			$error("escape_count expected %0d actual %0d", want.count, d[10:0]);
			errors++;
		end
		if (d[19:11] !== want.red) begin
			$error("red expected %0d actual %0d", $signed(want.red), $signed(d[19:11]));
			errors++;
		end
		if (d[27:20] !== want.green) begin
			$error("green expected %0d actual %0d", want.green, d[27:20]);
			errors++;
		end
		if (d[35:28] !== want.blue) begin
			$error("blue expected %0d actual %0d", want.blue, d[35:28]);
			errors++;
		end
	endfunction

	function void flush_check();
		if (awaited.size() != 0) begin
			$error("%0d pixel results never arrived", awaited.size());
			errors += awaited.size();
			awaited.delete();
		end
	endfunction
endclass

module mandelbrot_escape_time_pixel_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mbet_pkg::*;

	localparam logic [31:0] WORD_MAX = 32'h7FFFFFFF;
	localparam logic [31:0] WORD_MIN = 32'h80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_REAL_ORIGIN;
	logic [CFG_W-1:0] cfg_data = '0;

	escape_shades shades = new();
	int hold = 0;
	bit quiet = 1'b0;
	int views = 0;

	mandelbrot_escape_time_pixel i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [11:0] pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return 12'($urandom_range(0, 4095));
		end
		if (r < 8) begin
			return 12'($urandom_range(0, 63));
		end
		return (r == 8) ? 12'd0 : 12'd4095;
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return 32'd0;
			3: return 32'd1;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	// receiver: ready drops for a random stretch, possibly none, after each beat
	initial begin
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			shades.check_beat(m_tdata);
			hold = pick_gap();
		end
	end

	task automatic send_pixel(input logic [11:0] column, input logic [11:0] row);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {row, column};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		shades.note_pixel(column, row);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (shades.awaited.size() > 0) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		shades.write_register(idx, d);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_view(input logic [31:0] ro, input logic [31:0] io, input logic [31:0] rs,
			input logic [31:0] is, input logic [31:0] lim);
		write_cfg(REG_REAL_ORIGIN, ro);
		write_cfg(REG_IMAG_ORIGIN, io);
		write_cfg(REG_REAL_STEP, rs);
		write_cfg(REG_IMAG_STEP, is);
		write_cfg(REG_ITER_LIMIT, lim);
		views++;
	endtask

	task automatic stray_writes();
		for (int idx = int'(REG_ITER_LIMIT) + 1; idx < (1 << CFG_IDX_W); idx++) begin
			write_cfg(CFG_IDX_W'(idx), $urandom());
		end
	endtask

	initial begin
		#80ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int kind;
		int items;
		int sent;
		logic [31:0] ro;
		logic [31:0] io;
		logic [31:0] rs;
		logic [31:0] is;
		logic [10:0] lim;
		bit paused;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset view, registers outside the map must not disturb it
		stray_writes();
		views++;
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd0, 12'd2048);
		send_pixel(12'd1365, 12'd2048);
		send_pixel(12'd4095, 12'd2048);
		drain();
		write_cfg(REG_ITER_LIMIT, 32'd0);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd0, 12'd0);
		drain();
		write_cfg(REG_ITER_LIMIT, 32'd1);
		send_pixel(12'd2048, 12'd2048);
		drain();
		write_cfg(REG_ITER_LIMIT, 32'd1024);
		send_pixel(12'd2048, 12'd2048);
		drain();
		// limit beyond the cap, upper data bits set
		write_cfg(REG_ITER_LIMIT, 32'hFFFFFFFF);
		send_pixel(12'd1365, 12'd2048);
		drain();
		// mapped point saturates both ways
		set_view(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 32'd255);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd0);
		drain();
		set_view(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 32'd255);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		drain();
		set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd255);
		send_pixel(12'd123, 12'd456);
		drain();
		set_view(32'd134217728, -32'sd268435456, -32'sd196608, 32'sd131072, 32'd64);
		send_pixel(12'd4095, 12'd2048);
		send_pixel(12'd0, 12'd2048);
		drain();

		sent = 0;
		paused = 1'b0;
		while (sent < 400) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				ro = -32'sd671088640 + $urandom_range(0, 939524096);
				io = -32'sd402653184 + $urandom_range(0, 805306368);
				rs = $urandom_range(1, 1 << 18);
				is = $urandom_range(1, 1 << 18);
				if ($urandom_range(0, 3) == 0) begin
					rs = -rs;
				end
				if ($urandom_range(0, 3) == 0) begin
					is = -is;
				end
			end else if (kind < 8) begin
				ro = $urandom();
				io = $urandom();
				rs = $urandom();
				is = $urandom();
			end else if (kind == 8) begin
				ro = pick_extreme();
				io = pick_extreme();
				rs = pick_extreme();
				is = pick_extreme();
			end else begin
				ro = -32'sd536870912;
				io = -32'sd268435456;
				rs = 32'sd196608;
				is = 32'sd131072;
			end
			case ($urandom_range(0, 9))
				0: lim = 11'd0;
				1: lim = 11'd1;
				7: lim = 11'd255;
				8: lim = 11'd1024;
				9: lim = 11'($urandom_range(1025, 2047));
				default: lim = 11'($urandom_range(2, 64));
			endcase
			items = (lim >= 11'd255) ? $urandom_range(6, 12) : $urandom_range(20, 50);
			quiet = ($urandom_range(0, 4) == 0);
			set_view(ro, io, rs, is, {21'($urandom()), lim});
			if ($urandom_range(0, 2) == 0) begin
				stray_writes();
			end
			for (int i = 0; i < items; i++) begin
				if ((!paused && i == items / 2) || $urandom_range(0, 29) == 0) begin
					drain();
					paused = 1'b1;
				end
				send_pixel(pick_coord(), pick_coord());
				sent++;
			end
			drain();
		end

		quiet = 1'b0;
		repeat (100) @(posedge clk);
		shades.flush_check();
		$display("%0d pixels over %0d register settings: %0d escaped, %0d held to the cap",
			shades.pixels, views, shades.escaped, shades.pixels - shades.escaped);
		$display("deepest count %0d, negative red shades %0d", shades.max_seen, shades.neg_reds);
		if (shades.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

/* filelist.f */
hdl/mbet_pkg.sv
hdl/mandelbrot_escape_time_pixel.sv
dv/mandelbrot_escape_time_pixel_tb.sv
